@@ src/neighbor_table_evict_oldest_defines.svh @@
// Assertion macros for the neighbor table.
`ifndef NEIGHBOR_TABLE_EVICT_OLDEST_DEFINES_SVH
`define NEIGHBOR_TABLE_EVICT_OLDEST_DEFINES_SVH

`ifndef ASSERT_OFF
`define NTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NTE_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NTE_ASSERT(lbl, prop, msg)
`define NTE_ASSERT_NR(lbl, prop, msg)
`endif

`endif

@@ src/nte_pkg.sv @@
`default_nettype none
package nte_pkg;

  localparam int NODE_SLOTS_DEF  = 32;
  localparam int ALLOW_SLOTS_DEF = 16;
  localparam int KEY_W           = 256;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_INSERT  = 3'd1;
  localparam logic [2:0] ST_EVICT   = 3'd2;
  localparam logic [2:0] ST_LOADED  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic OP_ADVERT = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [7:0]       kind;
    logic [31:0]      lat;
    logic [31:0]      lon;
    logic [7:0]       sig;
    logic [31:0]      last_seen;
    logic [31:0]      first_seen;
    logic             allowed;
  } entry_t;

endpackage
`default_nettype wire

@@ src/nte_cell.sv @@
`default_nettype none
// One storage cell of a ring: loads from its neighbor or takes a direct write.
module nte_cell #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         shift_i,
  input  wire logic [W-1:0] shift_data_i,
  input  wire logic         wr_i,
  input  wire logic [W-1:0] wr_data_i,
  output logic [W-1:0]      q_o
);

  logic [W-1:0] data_q;
  logic [W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (wr_i) begin
      data_d = wr_data_i;
    end else if (shift_i) begin
      data_d = shift_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule
`default_nettype wire

@@ src/neighbor_table_evict_oldest.sv @@
// A load goes from idle straight to the finish state; an advert first scans both rings.
// The block takes one item at a time: an advert passes through the ring scan, finish and
// idle, a load through finish and idle; a waiting result delays the finish.
// Eviction is a shift-down of the cells above the victim.
// Reset (rst_ni low, asynchronous) clears the entry counts, the sequencer and the
// output valid; entry contents are not reset.
`default_nettype none
`include "neighbor_table_evict_oldest_defines.svh"
module neighbor_table_evict_oldest #(
  parameter int NODE_SLOTS  = nte_pkg::NODE_SLOTS_DEF,
  parameter int ALLOW_SLOTS = nte_pkg::ALLOW_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [63:0]        key_word_0_i,
  input  wire logic [63:0]        key_word_1_i,
  input  wire logic [63:0]        key_word_2_i,
  input  wire logic [63:0]        key_word_3_i,
  input  wire logic [7:0]         advert_kind_i,
  input  wire logic signed [31:0] latitude_i,
  input  wire logic signed [31:0] longitude_i,
  input  wire logic signed [7:0]  signal_level_i,
  input  wire logic [31:0]        now_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic [4:0]              slot_o,
  output logic                    allowed_o,
  output logic [5:0]              node_count_o,
  output logic [4:0]              allow_count_o
);
  import nte_pkg::*;

  localparam int MAXS = (NODE_SLOTS > ALLOW_SLOTS) ? NODE_SLOTS : ALLOW_SLOTS;
  localparam int SW   = $clog2(MAXS + 1);
  localparam int NIW  = $clog2(NODE_SLOTS);
  localparam int CW   = $clog2(NODE_SLOTS + 1);
  localparam int AW   = $clog2(ALLOW_SLOTS + 1);
  localparam int EW   = $bits(entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [SW-1:0]    step_q, step_d;
  logic [CW-1:0]    node_cnt_q, node_cnt_d;
  logic [AW-1:0]    allow_cnt_q, allow_cnt_d;
  logic             hit_q, hit_d;
  logic [NIW-1:0]   hit_idx_q, hit_idx_d;
  logic             allow_hit_q, allow_hit_d;
  logic [31:0]      min_q, min_d;
  logic [NIW-1:0]   victim_q, victim_d;
  entry_t           hit_ent_q, hit_ent_d;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       status_q, status_d;
  logic [4:0]       slot_q, slot_d;
  logic             allowed_q, allowed_d;

  // latched item
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [7:0]       kind_q;
  logic [31:0]      lat_q;
  logic [31:0]      lon_q;
  logic [7:0]       sig_q;
  logic [31:0]      now_q;

  entry_t           node_q [NODE_SLOTS];
  logic [KEY_W-1:0] allow_q [ALLOW_SLOTS];

  logic             accept;
  logic             can_emit;
  logic             node_rot;
  logic             allow_rot;
  logic             node_full;
  logic             evict;
  logic             node_wr;
  logic [CW-1:0]    node_widx;
  entry_t           node_wdata;
  logic             allow_wr;
  entry_t           new_ent;
  entry_t           head;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign can_emit  = !out_valid_q || !out_stall_i;
  assign node_rot  = (state_q == S_SCAN) && (step_q < SW'(NODE_SLOTS));
  assign allow_rot = (state_q == S_SCAN) && (step_q < SW'(ALLOW_SLOTS));
  assign node_full = (node_cnt_q == CW'(NODE_SLOTS));
  assign head      = node_q[0];

  always_comb begin
    new_ent            = '0;
    new_ent.key        = key_q;
    new_ent.kind       = kind_q;
    new_ent.lat        = lat_q;
    new_ent.lon        = lon_q;
    new_ent.sig        = sig_q;
    new_ent.last_seen  = now_q;
    new_ent.first_seen = now_q;
    new_ent.allowed    = allow_hit_q;
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    node_cnt_d  = node_cnt_q;
    allow_cnt_d = allow_cnt_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    allow_hit_d = allow_hit_q;
    min_d       = min_q;
    victim_d    = victim_q;
    hit_ent_d   = hit_ent_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    allowed_d   = allowed_q;
    evict       = 1'b0;
    node_wr     = 1'b0;
    node_widx   = node_cnt_q;
    node_wdata  = new_ent;
    allow_wr    = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          step_d      = '0;
          hit_d       = 1'b0;
          allow_hit_d = 1'b0;
          state_d     = (op_i == OP_LOAD) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        // head cell holds entry number step_q while the ring rotates
        if (node_rot) begin
          if (!hit_q && (step_q < SW'(node_cnt_q)) && (head.key == key_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = NIW'(step_q);
            hit_ent_d = head;
          end
          if ((step_q == '0) || (head.first_seen < min_q)) begin
            min_d    = head.first_seen;
            victim_d = NIW'(step_q);
          end
        end
        if (allow_rot && (step_q < SW'(allow_cnt_q)) && (allow_q[0] == key_q)) begin
          allow_hit_d = 1'b1;
        end
        step_d = step_q + SW'(1);
        if (step_q == SW'(MAXS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          allowed_d   = 1'b0;
          if (op_q == OP_LOAD) begin
            if (allow_cnt_q < AW'(ALLOW_SLOTS)) begin
              allow_wr    = 1'b1;
              slot_d      = 5'(allow_cnt_q);
              allow_cnt_d = allow_cnt_q + AW'(1);
              status_d    = ST_LOADED;
            end else begin
              slot_d   = '0;
              status_d = ST_FULL;
            end
          end else if (hit_q) begin
            node_wr              = 1'b1;
            node_widx            = CW'(hit_idx_q);
            node_wdata           = hit_ent_q;
            node_wdata.kind      = kind_q;
            node_wdata.sig       = sig_q;
            node_wdata.last_seen = now_q;
            // zero position means unknown: keep the stored one
            if ((lat_q != '0) || (lon_q != '0)) begin
              node_wdata.lat = lat_q;
              node_wdata.lon = lon_q;
            end
            slot_d    = 5'(hit_idx_q);
            allowed_d = hit_ent_q.allowed;
            status_d  = ST_UPDATED;
          end else if (node_full) begin
            evict     = 1'b1;
            slot_d    = 5'(NODE_SLOTS - 1);
            allowed_d = allow_hit_q;
            status_d  = ST_EVICT;
          end else begin
            node_wr    = 1'b1;
            slot_d     = 5'(node_cnt_q);
            allowed_d  = allow_hit_q;
            node_cnt_d = node_cnt_q + CW'(1);
            status_d   = ST_INSERT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      node_cnt_q  <= '0;
      allow_cnt_q <= '0;
      hit_q       <= 1'b0;
      allow_hit_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      node_cnt_q  <= node_cnt_d;
      allow_cnt_q <= allow_cnt_d;
      hit_q       <= hit_d;
      allow_hit_q <= allow_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    min_q     <= min_d;
    victim_q  <= victim_d;
    hit_ent_q <= hit_ent_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
    allowed_q <= allowed_d;
    if (accept) begin
      op_q   <= op_i;
      key_q  <= {key_word_0_i, key_word_1_i, key_word_2_i, key_word_3_i};
      kind_q <= advert_kind_i;
      lat_q  <= latitude_i;
      lon_q  <= longitude_i;
      sig_q  <= signal_level_i;
      now_q  <= now_ms_i;
    end
  end

  // node ring: rotates during the scan, shifts down above the victim on eviction
  for (genvar k = 0; k < NODE_SLOTS; k++) begin : g_node
    logic   shift_en;
    entry_t shift_in;
    entry_t cell_q;
    assign shift_en = node_rot || (evict && (NIW'(k) >= victim_q));
    if (k == NODE_SLOTS - 1) begin : g_top
      assign shift_in = node_rot ? node_q[0] : new_ent;
    end else begin : g_mid
      assign shift_in = node_q[k+1];
    end
    nte_cell #(.W(EW)) u_cell (
      .clk_i        (clk_i),
      .shift_i      (shift_en),
      .shift_data_i (shift_in),
      .wr_i         (node_wr && (node_widx == CW'(k))),
      .wr_data_i    (node_wdata),
      .q_o          (cell_q)
    );
    assign node_q[k] = cell_q;
  end

  for (genvar k = 0; k < ALLOW_SLOTS; k++) begin : g_allow
    nte_cell #(.W(KEY_W)) u_cell (
      .clk_i        (clk_i),
      .shift_i      (allow_rot),
      .shift_data_i (allow_q[(k + 1) % ALLOW_SLOTS]),
      .wr_i         (allow_wr && (allow_cnt_q == AW'(k))),
      .wr_data_i    (key_q),
      .q_o          (allow_q[k])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign allowed_o     = allowed_q;
  assign node_count_o  = 6'(node_cnt_q);
  assign allow_count_o = 5'(allow_cnt_q);

  `NTE_ASSERT(a_node_cnt_max, node_cnt_q <= CW'(NODE_SLOTS), "node count overflow")
  `NTE_ASSERT(a_allow_cnt_max, allow_cnt_q <= AW'(ALLOW_SLOTS), "allow count overflow")
  `NTE_ASSERT(a_hit_in_range,
              hit_q && (state_q == S_FIN) |-> CW'(hit_idx_q) < node_cnt_q,
              "hit index beyond valid entries")
  `NTE_ASSERT_NR(a_rst_idle, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
`default_nettype wire

@@ tb/sv/tb_neighbor_table_evict_oldest.sv @@
`timescale 1ns / 1ps
`default_nettype none

class neighbor_scoreboard;
  localparam int NODES = nte_pkg::NODE_SLOTS_DEF;
  localparam int ALLOWS = nte_pkg::ALLOW_SLOTS_DEF;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] slot;
    logic       allowed;
    logic [5:0] node_count;
    logic [4:0] allow_count;
  } verdict_t;

  logic [255:0] node_key[NODES];
  logic [31:0]  node_first[NODES];
  logic [31:0]  node_lat[NODES];
  logic [31:0]  node_lon[NODES];
  logic         node_allowed[NODES];
  logic [255:0] allow_key[ALLOWS];
  int           node_count;
  int           allow_count;
  verdict_t     pending[$];
  int           errors;
  int           checked;
  int           evictions;
  int           updates;

  function new();
    node_count = 0;
    allow_count = 0;
    errors = 0;
    checked = 0;
    evictions = 0;
    updates = 0;
  endfunction

  function void note_item(logic op, logic [255:0] key, logic [31:0] lat,
                          logic [31:0] lon, logic [31:0] now);
    verdict_t v;
    int hit;
    int victim;
    v = '0;
    if (op == nte_pkg::OP_LOAD) begin
      if (allow_count < ALLOWS) begin
        allow_key[allow_count] = key;
        v.slot = allow_count[4:0];
        allow_count++;
        v.status = nte_pkg::ST_LOADED;
      end else begin
        v.status = nte_pkg::ST_FULL;
      end
    end else begin
      hit = -1;
      for (int i = 0; i < node_count; i++)
        if (hit < 0 && node_key[i] == key) hit = i;
      if (hit >= 0) begin
        if (lat != 0 || lon != 0) begin
          node_lat[hit] = lat;
          node_lon[hit] = lon;
        end
        v.slot = hit[4:0];
        v.allowed = node_allowed[hit];
        v.status = nte_pkg::ST_UPDATED;
        updates++;
      end else begin
        v.status = nte_pkg::ST_INSERT;
        if (node_count >= NODES) begin
          victim = 0;
          for (int i = 1; i < NODES; i++)
            if (node_first[i] < node_first[victim]) victim = i;
          for (int i = victim; i + 1 < NODES; i++) begin
            node_key[i] = node_key[i+1];
            node_first[i] = node_first[i+1];
            node_lat[i] = node_lat[i+1];
            node_lon[i] = node_lon[i+1];
            node_allowed[i] = node_allowed[i+1];
          end
          node_count = NODES - 1;
          v.status = nte_pkg::ST_EVICT;
          evictions++;
        end
        node_key[node_count] = key;
        node_first[node_count] = now;
        node_lat[node_count] = lat;
        node_lon[node_count] = lon;
        node_allowed[node_count] = 1'b0;
        for (int i = 0; i < allow_count; i++)
          if (allow_key[i] == key) node_allowed[node_count] = 1'b1;
        v.slot = node_count[4:0];
        v.allowed = node_allowed[node_count];
        node_count++;
      end
    end
    v.node_count = node_count[5:0];
    v.allow_count = allow_count[4:0];
    pending.push_back(v);
  endfunction

  function void check_result(verdict_t got);
    verdict_t want;
    checked++;
    if (pending.size() == 0) begin
      report("result with nothing pending", 0, 0);
      return;
    end
    want = pending.pop_front();
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.slot != want.slot) report("slot", got.slot, want.slot);
    if (got.allowed != want.allowed) report("allowed", got.allowed, want.allowed);
    if (got.node_count != want.node_count)
      report("node_count", got.node_count, want.node_count);
    if (got.allow_count != want.allow_count)
      report("allow_count", got.allow_count, want.allow_count);
  endfunction

  function void report(string what, int got, int want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH result %0d %s: got %0d want %0d", checked, what, got, want);
  endfunction
endclass

module tb_neighbor_table_evict_oldest;
  import nte_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        op_i;
  logic [63:0] key_word_0_i, key_word_1_i, key_word_2_i, key_word_3_i;
  logic [7:0]  advert_kind_i;
  logic signed [31:0] latitude_i, longitude_i;
  logic signed [7:0]  signal_level_i;
  logic [31:0] now_ms_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [4:0]  slot_o;
  logic        allowed_o;
  logic [5:0]  node_count_o;
  logic [4:0]  allow_count_o;

  neighbor_table_evict_oldest dut (.*);

  neighbor_scoreboard table_model = new();
  logic [255:0] key_pool[24];
  logic [31:0]  clock_ms;
  int           idle_cycles;
  int           accepted;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [255:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // valid stays high into the next call so that back-to-back items need one update only
  task automatic send_item(logic op, logic [255:0] key, logic [7:0] kind,
                           logic [31:0] lat, logic [31:0] lon, logic [7:0] sig,
                           logic [31:0] now, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    {key_word_0_i, key_word_1_i, key_word_2_i, key_word_3_i} <= key;
    advert_kind_i <= kind;
    latitude_i <= lat;
    longitude_i <= lon;
    signal_level_i <= sig;
    now_ms_i <= now;
    do @(posedge clk_i); while (in_stall_o);
    table_model.note_item(op, key, lat, lon, now);
    accepted++;
    @(negedge clk_i);
  endtask

  // sink side: random stall pattern, result checked at the accepting edge
  initial begin
    int g;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      table_model.check_result({status_o, slot_o, allowed_o, node_count_o, allow_count_o});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("watchdog expired, %0d items pending", table_model.pending.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [255:0] k;
    logic [31:0] lat, lon;
    int r;
    idle_cycles = 0;
    accepted = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_ADVERT;
    key_word_0_i = '0; key_word_1_i = '0; key_word_2_i = '0; key_word_3_i = '0;
    advert_kind_i = '0; latitude_i = '0; longitude_i = '0;
    signal_level_i = '0; now_ms_i = '0;
    clock_ms = 32'd1000;
    for (int i = 0; i < 24; i++) key_pool[i] = random_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, allow-listed insert, hit with unknown position
    send_item(OP_LOAD, key_pool[1], 0, 0, 0, 0, 0, 0);
    send_item(OP_ADVERT, key_pool[0], 8'h00, 32'h8000_0000, 32'h7fff_ffff, 8'h80, 32'd0, 0);
    send_item(OP_ADVERT, key_pool[1], 8'hff, 32'h7fff_ffff, 32'h8000_0000, 8'h7f,
              32'hffff_ffff, 1);
    send_item(OP_ADVERT, key_pool[0], 8'h12, 32'd0, 32'd0, 8'hc4, 32'd5, 0);
    send_item(OP_ADVERT, key_pool[1], 8'h34, 32'd0, 32'd7, 8'h01, 32'd6, 0);
    // load after creation: existing entry stays unmarked
    send_item(OP_LOAD, key_pool[0], 0, 0, 0, 0, 0, 1);
    send_item(OP_LOAD, key_pool[0], 0, 0, 0, 0, 0, 0);
    send_item(OP_ADVERT, key_pool[0], 8'h01, 32'd1, 32'd0, 8'h00, 32'd9, 0);
    // fill table with equal first-seen times to force the lowest-index tie
    for (int i = 0; i < 32; i++)
      send_item(OP_ADVERT, random_key(), 8'($urandom), $urandom, $urandom,
                8'($urandom), 32'd3, 1);
    send_item(OP_ADVERT, key_pool[2], 8'h55, 32'd0, 32'd0, 8'h10, 32'd3, 0);

    // random: mostly adverts over a small key pool so hits and evictions are common
    for (int n = 0; n < 1250; n++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        k = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 23)] : random_key();
        send_item(OP_LOAD, k, 8'($urandom), $urandom, $urandom, 8'($urandom), $urandom,
                  n % 50 < 10);
      end else begin
        k = (r < 60) ? key_pool[$urandom_range(0, 23)] : random_key();
        if (r % 5 == 0) begin
          lat = 0; lon = 0;
        end else begin
          lat = $urandom; lon = $urandom;
        end
        clock_ms = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms + $urandom_range(0, 40);
        send_item(OP_ADVERT, k, 8'($urandom), lat, lon, 8'($urandom), clock_ms,
                  n % 50 < 10);
      end
    end
    in_valid_i <= 1'b0;

    wait (table_model.pending.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("%0d items sent, %0d results checked, %0d evictions, %0d refreshes",
             accepted, table_model.checked, table_model.evictions, table_model.updates);
    if (table_model.errors == 0 && table_model.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire
